// ===== rtl/adcerd_pkg.sv =====
// Shared types and constants for the ADC event record deframer.
// Used by adcerd_tracker, adcerd_out_reg and adc_event_record_deframer_core.
package adcerd_pkg;

	localparam int WORD_W    = 32;
	localparam int POS_W     = 12;
	localparam int RSL_W     = 12;
	localparam int EVC_W     = 9;
	localparam int CHAN_W    = 8;
	localparam int TIME_W    = 48;
	localparam int CFG_IDX_W = 1;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_RAW_SAMPLE_LENGTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ENERGY_VALUE_COUNT = 1'b1;

	// record length minus one, without the variable parts
	localparam logic [POS_W-1:0] FIXED_WORDS_M1 = 12'd5;
	localparam logic [POS_W-1:0] POS_HEADER     = 12'd0;
	localparam logic [POS_W-1:0] POS_TIME_LO    = 12'd1;
	// offsets back from the trailer position
	localparam logic [POS_W-1:0] OFS_MAX_ENERGY   = 12'd3;
	localparam logic [POS_W-1:0] OFS_FIRST_ENERGY = 12'd2;
	localparam logic [POS_W-1:0] OFS_FLAGS        = 12'd1;
	// largest position the counter reaches (longest record minus one)
	localparam logic [POS_W-1:0] POS_MAX = 12'd2563;

	localparam logic [CHAN_W-1:0] CHAN_OFFSET = 8'd64;

	localparam int BIT_NEIGHBOR_MINUS = 28;
	localparam int BIT_NEIGHBOR_PLUS  = 29;
	localparam int BIT_PILEUP         = 30;

	typedef struct packed {
		logic        pileup_flag;
		logic        neighbor_plus;
		logic        neighbor_minus;
	} flags_t;

	typedef struct packed {
		flags_t              flags;
		logic [TIME_W-1:0]   event_time;
		logic signed [WORD_W-1:0] event_energy;
		logic [CHAN_W-1:0]   channel_id;
	} result_t;

endpackage

// ===== rtl/adcerd_tracker.sv =====
// Record position counter and per-record field capture.
// Depends on adcerd_pkg.
module adcerd_tracker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [adcerd_pkg::WORD_W-1:0] data_word,
	input  logic                         buffer_end,
	input  logic [adcerd_pkg::RSL_W-1:0]  raw_sample_length,
	input  logic [adcerd_pkg::EVC_W-1:0]  energy_value_count,
	output logic                         emit,
	output adcerd_pkg::result_t          result,
	output logic [adcerd_pkg::POS_W-1:0]  position
);

	logic [adcerd_pkg::POS_W-1:0]  pos_q;
	logic [adcerd_pkg::POS_W-1:0]  last_pos;
	logic [adcerd_pkg::POS_W-1:0]  pos_next;
	logic [adcerd_pkg::CHAN_W-1:0] chan_q;
	logic [adcerd_pkg::TIME_W-1:0] time_q;
	logic [adcerd_pkg::WORD_W-1:0] max_q;
	logic [adcerd_pkg::WORD_W-1:0] first_q;
	adcerd_pkg::flags_t            flags_q;

	// trailer position = record length - 1
	assign last_pos = adcerd_pkg::FIXED_WORDS_M1
		+ {1'b0, raw_sample_length[adcerd_pkg::RSL_W-1:1]}
		+ {{(adcerd_pkg::POS_W-adcerd_pkg::EVC_W){1'b0}}, energy_value_count};

	// at or past the trailer (also after a shrinking register write)
	assign emit = (pos_q >= last_pos);

	always_comb begin
		if (emit || buffer_end) begin
			pos_next = '0;
		end else begin
			pos_next = pos_q + 12'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			chan_q  <= '0;
			time_q  <= '0;
			max_q   <= '0;
			first_q <= '0;
			flags_q <= '0;
		end else if (accept) begin
			pos_q <= pos_next;
			if (!emit) begin
				priority if (pos_q == adcerd_pkg::POS_HEADER) begin
					chan_q <= {data_word[15:11], data_word[2:0]} - adcerd_pkg::CHAN_OFFSET;
					time_q <= {data_word[31:16], 32'd0};
				end else if (pos_q == adcerd_pkg::POS_TIME_LO) begin
					time_q[adcerd_pkg::WORD_W-1:0] <= data_word;
				end else if (pos_q == last_pos - adcerd_pkg::OFS_MAX_ENERGY) begin
					max_q <= data_word;
				end else if (pos_q == last_pos - adcerd_pkg::OFS_FIRST_ENERGY) begin
					first_q <= data_word;
				end else if (pos_q == last_pos - adcerd_pkg::OFS_FLAGS) begin
					flags_q.neighbor_minus <= data_word[adcerd_pkg::BIT_NEIGHBOR_MINUS];
					flags_q.neighbor_plus  <= data_word[adcerd_pkg::BIT_NEIGHBOR_PLUS];
					flags_q.pileup_flag    <= data_word[adcerd_pkg::BIT_PILEUP];
				end else begin
					// raw sample and energy filter words are dropped
				end
			end
		end
	end

	always_comb begin
		result.channel_id   = chan_q;
		result.event_energy = $signed(max_q - first_q);
		result.event_time   = time_q;
		result.flags        = flags_q;
	end

	assign position = pos_q;

endmodule

// ===== rtl/adcerd_out_reg.sv =====
// Result register on the master side of the deframer.
// Depends on adcerd_pkg.
module adcerd_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  adcerd_pkg::result_t load_data,
	output logic                free,
	output logic                out_valid,
	input  logic                out_ready,
	output adcerd_pkg::result_t out_data
);

	logic                valid_q;
	adcerd_pkg::result_t data_q;

	// slot can take a new result this cycle if empty or being drained
	assign free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// ===== rtl/adc_event_record_deframer_core.sv =====
// Top level of the ADC event record deframer: config registers, tracker, result register.
// Depends on adcerd_pkg, adcerd_tracker and adcerd_out_reg.
//
// Use: readout words enter on the s_ stream, one beat per 32-bit word, with
// s_tlast marking the final word of a readout buffer. Each fixed-length record
// (6 + raw_sample_length/2 + energy_value_count words) yields one beat on the
// m_ stream when its trailer word is taken; all other words give no beat.
// Throughput: one word per cycle while s_tready is high. The result beat appears in the
// cycle after the trailer word is accepted, from a single result register.
// s_tready is low only when the next word is a trailer and the result register
// still holds an untaken beat; other words keep flowing while m_ stalls.
// s_tlast returns the record position to zero and drops any partial record. The user
// must write configuration through cfg_we/cfg_index/cfg_wdata only while idle; the block
// does not enforce it. Reset clears the registers, position and all held record fields.
module adc_event_record_deframer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [adcerd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [adcerd_pkg::RSL_W-1:0]     cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] data_word
	input  logic        s_tlast,   // buffer_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // [7:0] channel_id, [39:8] event_energy, [87:40] event_time
	output logic [2:0]  m_tuser    // [0] neighbor_minus, [1] neighbor_plus, [2] pileup_flag
);

	logic [adcerd_pkg::RSL_W-1:0] rsl_q;
	logic [adcerd_pkg::EVC_W-1:0] evc_q;
	logic                         accept;
	logic                         emit;
	logic                         slot_free;
	logic [adcerd_pkg::POS_W-1:0] position;
	adcerd_pkg::result_t          trk_result;
	adcerd_pkg::result_t          out_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsl_q <= '0;
			evc_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				adcerd_pkg::REG_RAW_SAMPLE_LENGTH:  rsl_q <= cfg_wdata;
				adcerd_pkg::REG_ENERGY_VALUE_COUNT: evc_q <= cfg_wdata[adcerd_pkg::EVC_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_tready = !emit || slot_free;
	assign accept   = s_tvalid && s_tready;

	adcerd_tracker u_tracker (
		.clk                (clk),
		.arst_n             (arst_n),
		.accept             (accept),
		.data_word          (s_tdata),
		.buffer_end         (s_tlast),
		.raw_sample_length  (rsl_q),
		.energy_value_count (evc_q),
		.emit               (emit),
		.result             (trk_result),
		.position           (position)
	);

	adcerd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept && emit),
		.load_data (trk_result),
		.free      (slot_free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_result)
	);

	assign m_tdata = {out_result.event_time, out_result.event_energy, out_result.channel_id};
	assign m_tuser = {out_result.flags.pileup_flag, out_result.flags.neighbor_plus,
		out_result.flags.neighbor_minus};

	// a trailer beat always reaches the result register
	a_emit_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && emit) |=> m_tvalid)
		else $error("trailer word produced no result beat");

	// no beat appears without a trailer word
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid && !(accept && emit)) |=> !m_tvalid)
		else $error("result beat without trailer word");

	// buffer end always rewinds the record position
	a_buffer_end: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tlast) |=> (position == '0))
		else $error("position not cleared after buffer end");

	// position never runs past the longest possible record
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		position <= adcerd_pkg::POS_MAX)
		else $error("record position out of range");

endmodule

// ===== tb/adc_event_record_deframer_core_tb.sv =====
// Self-checking bench for adc_event_record_deframer_core: random and directed readout words,
// a scoreboard class that predicts each event beat, random stalls on both streams.
// Depends on adcerd_pkg and the deframer RTL.
module adc_event_record_deframer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;

	class deframe_scoreboard;
		logic [adcerd_pkg::RSL_W-1:0]  raw_len;
		logic [adcerd_pkg::EVC_W-1:0]  energy_cnt;
		logic [adcerd_pkg::POS_W-1:0]  pos;
		logic [adcerd_pkg::CHAN_W-1:0] chan_q;
		logic [adcerd_pkg::TIME_W-1:0] time_q;
		logic [adcerd_pkg::WORD_W-1:0] max_q;
		logic [adcerd_pkg::WORD_W-1:0] first_q;
		adcerd_pkg::flags_t            flags_q;
		adcerd_pkg::result_t           events_due[$];
		int                            mismatches;
		int                            compared;

		function new();
			raw_len    = '0;
			energy_cnt = '0;
			pos        = '0;
			chan_q     = '0;
			time_q     = '0;
			max_q      = '0;
			first_q    = '0;
			flags_q    = '0;
			mismatches = 0;
			compared   = 0;
		endfunction

		function void set_cfg(logic [adcerd_pkg::CFG_IDX_W-1:0] idx,
				logic [adcerd_pkg::RSL_W-1:0] val);
			if (idx == adcerd_pkg::REG_RAW_SAMPLE_LENGTH)
				raw_len = val;
			else
				energy_cnt = val[adcerd_pkg::EVC_W-1:0];
		endfunction

		function logic [adcerd_pkg::POS_W-1:0] record_len();
			logic [adcerd_pkg::POS_W-1:0] half_len;
			logic [adcerd_pkg::POS_W-1:0] cnt;
			half_len = {1'b0, raw_len[adcerd_pkg::RSL_W-1:1]};
			cnt      = {{(adcerd_pkg::POS_W-adcerd_pkg::EVC_W){1'b0}}, energy_cnt};
			return adcerd_pkg::FIXED_WORDS_M1 + 12'd1 + half_len + cnt;
		endfunction

		function void note_word(logic [adcerd_pkg::WORD_W-1:0] word, logic last);
			logic [adcerd_pkg::POS_W-1:0] trl;
			adcerd_pkg::result_t ev;
			trl = record_len() - 12'd1;
			// a shrunk record length can leave pos past the trailer: take it as the trailer
			if (pos >= trl) begin
				ev.channel_id   = chan_q;
				ev.event_energy = max_q - first_q;
				ev.event_time   = time_q;
				ev.flags        = flags_q;
				events_due.push_back(ev);
				pos = '0;
			end else begin
				if (pos == adcerd_pkg::POS_HEADER) begin
					chan_q = {word[15:11], word[2:0]} - adcerd_pkg::CHAN_OFFSET;
					time_q = {word[31:16], 32'h0};
				end else if (pos == adcerd_pkg::POS_TIME_LO) begin
					time_q[31:0] = word;
				end else if (pos == trl - adcerd_pkg::OFS_MAX_ENERGY) begin
					max_q = word;
				end else if (pos == trl - adcerd_pkg::OFS_FIRST_ENERGY) begin
					first_q = word;
				end else if (pos == trl - adcerd_pkg::OFS_FLAGS) begin
					flags_q.neighbor_minus = word[adcerd_pkg::BIT_NEIGHBOR_MINUS];
					flags_q.neighbor_plus  = word[adcerd_pkg::BIT_NEIGHBOR_PLUS];
					flags_q.pileup_flag    = word[adcerd_pkg::BIT_PILEUP];
				end
				pos = pos + 12'd1;
			end
			if (last)
				pos = '0;
		endfunction

		function void check_result(logic [87:0] tdata, logic [2:0] tuser);
			adcerd_pkg::result_t want;
			adcerd_pkg::result_t got;
			got.channel_id   = tdata[7:0];
			got.event_energy = tdata[39:8];
			got.event_time   = tdata[87:40];
			got.flags        = tuser;
			if (events_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected event beat: chan %0d energy %0d time %h flags %b",
						got.channel_id, got.event_energy, got.event_time, got.flags);
				return;
			end
			want = events_due.pop_front();
			compared++;
			if (got.channel_id !== want.channel_id || got.event_energy !== want.event_energy ||
					got.event_time !== want.event_time || got.flags !== want.flags) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("event %0d: exp chan %0d energy %0d time %h flags %b", compared,
						want.channel_id, want.event_energy, want.event_time, want.flags);
					$display("event %0d: got chan %0d energy %0d time %h flags %b", compared,
						got.channel_id, got.event_energy, got.event_time, got.flags);
				end
			end
		endfunction
	endclass

	logic                                clk       = 1'b0;
	logic                                arst_n    = 1'b0;
	logic                                cfg_we    = 1'b0;
	logic [adcerd_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
	logic [adcerd_pkg::RSL_W-1:0]        cfg_wdata = '0;
	logic                                s_tvalid  = 1'b0;
	logic                                s_tready;
	logic [31:0]                         s_tdata   = '0;
	logic                                s_tlast   = 1'b0;
	logic                                m_tvalid;
	logic                                m_tready  = 1'b0;
	logic [87:0]                         m_tdata;
	logic [2:0]                          m_tuser;

	deframe_scoreboard sb = new();
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int words_sent     = 0;
	int settings_run   = 0;
	int cycle_count    = 0;

	adc_event_record_deframer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// result beats come in the cycle after their trailer, so check before noting this edge's word
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tuser);
			if (s_tvalid && s_tready)
				sb.note_word(s_tdata, s_tlast);
		end
	end

	// each cycle the sender idles with probability send_idle_pct
	task automatic send_word(input logic [adcerd_pkg::WORD_W-1:0] w, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		words_sent++;
	endtask

	// hold off the sender until every event beat has been taken
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.events_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic [adcerd_pkg::RSL_W-1:0] rsl,
			input logic [adcerd_pkg::EVC_W-1:0] evc);
		logic [adcerd_pkg::RSL_W-1:0] evc_wide;
		evc_wide = {{(adcerd_pkg::RSL_W-adcerd_pkg::EVC_W){1'b0}}, evc};
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= adcerd_pkg::REG_RAW_SAMPLE_LENGTH;
		cfg_wdata <= rsl;
		@(posedge clk);
		cfg_index <= adcerd_pkg::REG_ENERGY_VALUE_COUNT;
		cfg_wdata <= evc_wide;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_cfg(adcerd_pkg::REG_RAW_SAMPLE_LENGTH, rsl);
		sb.set_cfg(adcerd_pkg::REG_ENERGY_VALUE_COUNT, evc_wide);
		settings_run++;
		@(posedge clk);
	endtask

	task automatic send_six(input logic [adcerd_pkg::WORD_W-1:0] hdr,
			input logic [adcerd_pkg::WORD_W-1:0] tlo,
			input logic [adcerd_pkg::WORD_W-1:0] mx, input logic [adcerd_pkg::WORD_W-1:0] fst,
			input logic [adcerd_pkg::WORD_W-1:0] flg, input logic last);
		send_word(hdr, 1'b0);
		send_word(tlo, 1'b0);
		send_word(mx, 1'b0);
		send_word(fst, 1'b0);
		send_word(flg, 1'b0);
		send_word($urandom(), last);
	endtask

	function automatic logic [adcerd_pkg::WORD_W-1:0] energy_word();
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	// cut_at inside the record puts buffer_end on that word and stops there
	task automatic send_record(input int cut_at, input logic end_on_trailer);
		int len;
		logic [adcerd_pkg::WORD_W-1:0] w;
		len = int'(sb.record_len());
		for (int i = 0; i < len; i++) begin
			w = (i == len - 4 || i == len - 3) ? energy_word() : $urandom();
			if (i == cut_at) begin
				send_word(w, 1'b1);
				break;
			end
			send_word(w, (i == len - 1) && end_on_trailer);
		end
	endtask

	task automatic random_phase(input int n_words);
		int stop_at;
		int pick;
		stop_at = words_sent + n_words;
		while (words_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 80)
				send_record(-1, $urandom_range(9) == 0);
			else if (pick < 92)
				send_record($urandom_range(int'(sb.record_len()) - 1), 1'b0);
			else
				send_word($urandom(), 1'($urandom_range(1)));
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct  = 19;
		recv_stall_pct = 66;
		// six-word records at the reset lengths
		send_six(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7000_0000, 1'b0);
		send_six(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 1'b1);
		// dropped partial record, then buffer end on a header word
		send_word(32'h0000_8805, 1'b0);
		send_word(32'hA5A5_5A5A, 1'b0);
		send_word(32'h0F0F_F0F0, 1'b1);
		send_word(32'h1234_F807, 1'b1);
		send_six(32'h8000_4003, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, 32'h2000_0000, 1'b0);
		send_six(32'h5555_AAAA, 32'hAAAA_5555, 32'h0000_0010, 32'h0000_0020, 32'h5000_0000, 1'b0);

		set_config(12'd0, 9'd0);
		random_phase(250);
		set_config(12'd5, 9'd1);
		random_phase(200);

		send_idle_pct  = 66;
		recv_stall_pct = 19;
		// leave a record half done, then shrink the record under it
		set_config(12'd40, 9'd10);
		for (int i = 0; i < 20; i++)
			send_word($urandom(), 1'b0);
		set_config(12'd0, 9'd0);
		random_phase(150);
		set_config(12'd201, 9'd40);
		send_record(-1, 1'b0);
		send_record(5, 1'b0);

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		set_config(12'd3, 9'd2);
		random_phase(300);
		set_config(12'd2, 9'd0);
		random_phase(200);
		drain();

		$display("%0d readout words over %0d register settings, %0d event beats compared",
			words_sent, settings_run, sb.compared);
		if (sb.mismatches == 0 && sb.events_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
